/* hdl/chacha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared constants, microcode control word and microcode ROM for the
// ChaCha20 keystream byte generator.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int BLOCK_BYTES   = 64;
  localparam int LEFT_W        = 7;
  localparam int ROUND_W       = $clog2(DOUBLE_ROUNDS);
  localparam int PC_W          = 4;
  localparam int CFG_W         = 64;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_KEY01   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY23   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY45   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY67   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NONCE01 = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_NONCE2  = 3'd5;

  // micro-operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ROUND = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_SERVE = 2'd3;

  // program addresses
  localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
  localparam logic [PC_W-1:0] PC_LOOP  = 4'd1;
  localparam logic [PC_W-1:0] PC_SERVE = 4'd10;

  typedef struct packed {
    logic [1:0]      op;
    logic            diag;    // 0: column round, 1: diagonal round
    logic [1:0]      line;    // which quarter-round line
    logic            loop;    // jump to target while rounds remain
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_SERVE, diag: 1'b0, line: 2'd0, loop: 1'b0, target: PC_LOAD};
    unique case (pc)
      4'd0:  w.op = OP_LOAD;
      4'd1:  begin w.op = OP_ROUND; w.line = 2'd0; end
      4'd2:  begin w.op = OP_ROUND; w.line = 2'd1; end
      4'd3:  begin w.op = OP_ROUND; w.line = 2'd2; end
      4'd4:  begin w.op = OP_ROUND; w.line = 2'd3; end
      4'd5:  begin w.op = OP_ROUND; w.diag = 1'b1; w.line = 2'd0; end
      4'd6:  begin w.op = OP_ROUND; w.diag = 1'b1; w.line = 2'd1; end
      4'd7:  begin w.op = OP_ROUND; w.diag = 1'b1; w.line = 2'd2; end
      4'd8:  begin
        w.op = OP_ROUND; w.diag = 1'b1; w.line = 2'd3;
        w.loop = 1'b1; w.target = PC_LOOP;
      end
      4'd9:  w.op = OP_ADD;
      4'd10: w.op = OP_SERVE;
      default: w.op = OP_SERVE;
    endcase
    return w;
  endfunction

  // rotate left by the fixed amount of each quarter-round line
  function automatic logic [31:0] rotl_line(input logic [31:0] x, input logic [1:0] line);
    logic [31:0] r;
    case (line)
      2'd0:    r = {x[15:0], x[31:16]};
      2'd1:    r = {x[19:0], x[31:20]};
      2'd2:    r = {x[23:0], x[31:24]};
      default: r = {x[24:0], x[31:25]};
    endcase
    return r;
  endfunction

endpackage

/* hdl/chacha20_keystream_byte_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_keystream_byte_generator_unit
// Serves one ChaCha20 keystream byte per transfer; a microcoded sequencer
// drives four quarter-round lanes to build each 64-byte block.
// ----------------------------------------------------------------------------
// Channel | Handshake              | Payload
// --------+------------------------+-------------------------------
// input   | in_valid / in_ready    | restart
// output  | out_valid / out_ready  | random_byte
// config  | cfg_we (no wait)       | cfg_addr, cfg_data
//
// A byte from the current block is in the output register after its request
// transfer and the serve step, and the next request can transfer once the
// serve step is done. A request that needs a new block runs one load step,
// 8 steps per double round (one quarter-round line per step over four lanes),
// one add step and the serve step.
// One request is in work at a time; a stalled output holds the serve step.
// in_ready is low while a config write is on the port.
// Sync reset clears key, nonce, counter, bytes left and all handshake state.
// ----------------------------------------------------------------------------
module chacha20_keystream_byte_generator_unit
  import chacha_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            random_byte,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic [63:0] key01, key23, key45, key67, nonce01;
  logic [31:0] nonce2;

  logic [31:0]        block_counter;
  logic [LEFT_W-1:0]  bytes_left;
  logic [LEFT_W-1:0]  left_eff;
  logic               running;
  logic [PC_W-1:0]    pc;
  logic [ROUND_W-1:0] round_cnt;

  logic [31:0] ks [16];
  logic [31:0] rs [16];
  logic [31:0] rs_next [16];

  ucode_t      uw;
  logic        in_xfer;
  logic        out_free;
  logic        serve_go;
  logic        need_refill;
  logic [5:0]  pos;
  logic [31:0] counter_inc;
  logic [31:0] sel_word;

  logic [3:0]  ai, bi, ci, di, xi, yi, zi;
  logic [31:0] sum;

  assign uw          = ucode_rom(pc);
  assign in_ready    = !running && !cfg_we;
  assign in_xfer     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign serve_go    = running && !cfg_we && (uw.op == OP_SERVE) && out_free;
  assign left_eff    = restart ? '0 : bytes_left;
  assign need_refill = (left_eff == '0) || (left_eff > LEFT_W'(BLOCK_BYTES));
  assign counter_inc = block_counter + 32'd1;
  // position in block is 64 - bytes_left, modulo 64
  assign pos         = 6'(~bytes_left + 7'd1);
  assign sel_word    = ks[pos[5:2]];

  // four independent quarter-round lanes; diagonal rounds rotate the rows
  always_comb begin
    for (int i = 0; i < 16; i++) rs_next[i] = rs[i];
    ai = '0; bi = '0; ci = '0; di = '0; xi = '0; yi = '0; zi = '0; sum = '0;
    for (int q = 0; q < 4; q++) begin
      ai = {2'b00, 2'(q)};
      bi = {2'b01, 2'(q + int'(uw.diag))};
      ci = {2'b10, 2'(q + 2 * int'(uw.diag))};
      di = {2'b11, 2'(q + 3 * int'(uw.diag))};
      if (!uw.line[0]) begin
        xi = ai; yi = bi; zi = di;
      end else begin
        xi = ci; yi = di; zi = bi;
      end
      sum = rs[xi] + rs[yi];
      rs_next[xi] = sum;
      rs_next[zi] = rotl_line(rs[zi] ^ sum, uw.line);
    end
  end

  // output valid: set by the serve step, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (serve_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      pc            <= PC_LOAD;
      round_cnt     <= '0;
      block_counter <= '0;
      bytes_left    <= '0;
      key01         <= '0;
      key23         <= '0;
      key45         <= '0;
      key67         <= '0;
      nonce01       <= '0;
      nonce2        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_KEY01:   key01   <= cfg_data;
          REG_KEY23:   key23   <= cfg_data;
          REG_KEY45:   key45   <= cfg_data;
          REG_KEY67:   key67   <= cfg_data;
          REG_NONCE01: nonce01 <= cfg_data;
          REG_NONCE2:  nonce2  <= cfg_data[31:0];
          default: ;
        endcase
        if (cfg_addr <= REG_NONCE2) begin
          block_counter <= '0;
          bytes_left    <= '0;
        end
      end else if (in_xfer) begin
        running <= 1'b1;
        pc      <= need_refill ? PC_LOAD : PC_SERVE;
        if (restart) begin
          block_counter <= '0;
          bytes_left    <= '0;
        end
      end else if (running) begin
        unique case (uw.op)
          OP_LOAD: begin
            block_counter <= counter_inc;
            round_cnt     <= ROUND_W'(DOUBLE_ROUNDS - 1);
            pc            <= pc + 1'b1;
          end
          OP_ROUND: begin
            if (uw.loop && round_cnt != '0) begin
              round_cnt <= round_cnt - 1'b1;
              pc        <= uw.target;
            end else begin
              pc <= pc + 1'b1;
            end
          end
          OP_ADD: begin
            bytes_left <= LEFT_W'(BLOCK_BYTES);
            pc         <= pc + 1'b1;
          end
          OP_SERVE: begin
            if (out_free) begin
              bytes_left <= bytes_left - 1'b1;
              running    <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath: block words, working words and output byte
  always_ff @(posedge clk) begin
    if (running && !cfg_we && !in_xfer) begin
      case (uw.op)
        OP_LOAD: begin
          ks[0]  <= SIGMA0;          rs[0]  <= SIGMA0;
          ks[1]  <= SIGMA1;          rs[1]  <= SIGMA1;
          ks[2]  <= SIGMA2;          rs[2]  <= SIGMA2;
          ks[3]  <= SIGMA3;          rs[3]  <= SIGMA3;
          ks[4]  <= key01[31:0];     rs[4]  <= key01[31:0];
          ks[5]  <= key01[63:32];    rs[5]  <= key01[63:32];
          ks[6]  <= key23[31:0];     rs[6]  <= key23[31:0];
          ks[7]  <= key23[63:32];    rs[7]  <= key23[63:32];
          ks[8]  <= key45[31:0];     rs[8]  <= key45[31:0];
          ks[9]  <= key45[63:32];    rs[9]  <= key45[63:32];
          ks[10] <= key67[31:0];     rs[10] <= key67[31:0];
          ks[11] <= key67[63:32];    rs[11] <= key67[63:32];
          ks[12] <= counter_inc;     rs[12] <= counter_inc;
          ks[13] <= nonce01[31:0];   rs[13] <= nonce01[31:0];
          ks[14] <= nonce01[63:32];  rs[14] <= nonce01[63:32];
          ks[15] <= nonce2;          rs[15] <= nonce2;
        end
        OP_ROUND: begin
          for (int i = 0; i < 16; i++) rs[i] <= rs_next[i];
        end
        OP_ADD: begin
          for (int i = 0; i < 16; i++) ks[i] <= ks[i] + rs[i];
        end
        OP_SERVE: begin
          if (out_free) random_byte <= 8'(sel_word >> {pos[1:0], 3'b000});
        end
        default: ;
      endcase
    end
  end

endmodule

/* verif/tb_chacha20_keystream_byte_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha20_keystream_byte_generator_unit
// Self-checking bench for the keystream byte generator. Requests go in on the
// valid/ready input channel, and every keystream byte is compared with a
// bit-exact software ChaCha20 block model. The run covers all-zero,
// all-one and random key/nonce settings, restarts, ignored register
// indexes and random idling on both sides, including a long output stall.
// ----------------------------------------------------------------------------
module tb_chacha20_keystream_byte_generator_unit
  import chacha_pkg::*;
();

  class keystream_scoreboard;

    logic [CFG_W-1:0] key_pair [4];
    logic [63:0]      nonce_lo;
    logic [31:0]      nonce_hi;
    logic [31:0]      block_ctr;
    int unsigned      bytes_rem;
    logic [31:0]      ks_words [16];
    logic [31:0]      mix [16];
    logic [7:0]       expected_bytes [$];
    int               errors;
    int               served;

    function new();
      foreach (key_pair[i]) key_pair[i] = '0;
      nonce_lo  = '0;
      nonce_hi  = '0;
      block_ctr = '0;
      bytes_rem = 0;
      errors    = 0;
      served    = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_KEY01:   key_pair[0] = data;
        REG_KEY23:   key_pair[1] = data;
        REG_KEY45:   key_pair[2] = data;
        REG_KEY67:   key_pair[3] = data;
        REG_NONCE01: nonce_lo = data;
        REG_NONCE2:  nonce_hi = data[31:0];
        default:     return;
      endcase
      block_ctr = '0;
      bytes_rem = 0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    function void build_block();
      block_ctr   = block_ctr + 32'd1;   // wraps mod 2^32
      ks_words[0] = 32'h6170_7865;
      ks_words[1] = 32'h3320_646e;
      ks_words[2] = 32'h7962_2d32;
      ks_words[3] = 32'h6b20_6574;
      for (int i = 0; i < 4; i++) begin
        ks_words[4 + 2*i] = key_pair[i][31:0];
        ks_words[5 + 2*i] = key_pair[i][63:32];
      end
      ks_words[12] = block_ctr;
      ks_words[13] = nonce_lo[31:0];
      ks_words[14] = nonce_lo[63:32];
      ks_words[15] = nonce_hi;
      mix = ks_words;
      for (int r = 0; r < 10; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] += mix[i];
      bytes_rem = 64;
    endfunction

    function void note_request(bit restart_req);
      int unsigned pos;
      logic [31:0] word;
      if (restart_req) begin
        block_ctr = '0;
        bytes_rem = 0;
      end
      if (bytes_rem == 0 || bytes_rem > 64) build_block();
      pos  = 64 - bytes_rem;
      word = ks_words[pos >> 2];
      expected_bytes.push_back(word[8*(pos % 4) +: 8]);
      bytes_rem--;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte 0x%02h with no request outstanding", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want)
          report($sformatf("byte %0d random_byte got 0x%02h exp 0x%02h", served, got, want));
        served++;
      end
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction

  endclass

  localparam int STALL_LIMIT = 5000;   // longest legal gap: the receiver hold-off plus one block refill
  localparam int SETTLE      = 100;    // a bit over one block refill
  localparam int HOLD_CYCLES = 300;
  // indexes past the register list; writes there are ignored
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE7 = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  restart;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            random_byte;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_data;

  keystream_scoreboard sb;
  int send_idle;
  int recv_idle;
  bit hold_off_req;
  int stall_cycles;

  chacha20_keystream_byte_generator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_byte (random_byte),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // transfer monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(restart);
      if (out_valid && out_ready) sb.check_byte(random_byte);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("chacha20_keystream_byte_generator_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // returns right after the posedge at which the request transfers
  task automatic send_request(input bit rs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      restart  <= $urandom_range(1);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_request($urandom_range(63) == 0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic write_all(input bit ones);
    write_reg(REG_KEY01,   ones ? '1 : {$urandom, $urandom});
    write_reg(REG_KEY23,   ones ? '1 : {$urandom, $urandom});
    write_reg(REG_KEY45,   ones ? '1 : {$urandom, $urandom});
    write_reg(REG_KEY67,   ones ? '1 : {$urandom, $urandom});
    write_reg(REG_NONCE01, ones ? '1 : {$urandom, $urandom});
    write_reg(REG_NONCE2,  ones ? '1 : {$urandom, $urandom});
  endtask

  initial begin
    bit directed_restart [20] = '{0, 0, 0, 0, 0, 1, 0, 0, 1, 1,
                                  0, 0, 0, 0, 1, 0, 0, 0, 0, 0};
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    restart      = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_data     = '0;
    send_idle    = 34;
    recv_idle    = 73;
    hold_off_req = 1'b0;
    stall_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all-zero key after reset; restart mid-block and back to back
    foreach (directed_restart[i]) send_request(directed_restart[i]);
    drain();

    // all-ones key and nonce; write lands mid-block and clears counters
    write_all(1'b1);
    send_random(400);
    drain();

    send_idle = 73;
    recv_idle = 34;
    write_all(1'b0);
    send_random(200);
    hold_off_req = 1'b1;   // output stalls long, input backs up
    send_random(200);
    drain();

    // unused indexes: counters must carry on from mid-block
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_SPARE6, '1);
    write_reg(REG_SPARE7, {$urandom, $urandom});
    send_random(200);
    drain();

    write_reg(REG_NONCE2, {$urandom, $urandom});
    send_random(230);
    drain();

    if (sb.pending() != 0) sb.report($sformatf("%0d bytes never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("chacha20_keystream_byte_generator_unit test passed");
    end else begin
      $display("chacha20_keystream_byte_generator_unit test failed");
    end
    $finish;
  end

endmodule
